/* hdl/assert_macros.svh */
// Assertion helpers shared by the thermistor conversion RTL.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tac_pkg.sv */
package tac_pkg;

  localparam int ADC_BITS_DEF  = 12;
  localparam int COEF_FRAC_DEF = 48;
  localparam int TEMP_FRAC_DEF = 8;

  localparam int COEF_W     = 40;
  localparam int SERIES_W   = 20;
  localparam int TEMP_W     = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [COEF_W-1:0]   COEF_A_RST = 40'd317826906880;
  localparam logic [COEF_W-1:0]   COEF_B_RST = 40'd65900328960;
  localparam logic [COEF_W-1:0]   COEF_C_RST = 40'd24678042;
  localparam logic [SERIES_W-1:0] SERIES_RST = 20'd10000;

  // ln(2) in Q0.24
  localparam int               LN2_W   = 24;
  localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // quotient bits at or above this weight saturate the divider
  localparam int SAT_BIT = 62;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A = 2'd0,
    CFG_COEF_B = 2'd1,
    CFG_COEF_C = 2'd2,
    CFG_SERIES = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic raised;
    logic zero_r;
  } tac_flags_t;

endpackage

/* hdl/tac_front.sv */
`include "assert_macros.svh"

module tac_front #(
  parameter int ADC_BITS = tac_pkg::ADC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [ADC_BITS-1:0]                      in_adc_code,
  input  logic [tac_pkg::SERIES_W-1:0]             series_ohms,
  output logic                                     q_valid,
  input  logic                                     q_ready,
  output logic [ADC_BITS-1:0]                      q_code,
  output logic [tac_pkg::SERIES_W+ADC_BITS-1:0]    q_num,
  output tac_pkg::tac_flags_t                      q_flags
);
  import tac_pkg::*;

  localparam int                NUM_W = SERIES_W + ADC_BITS;
  localparam logic [ADC_BITS-1:0] FS  = '1;

  logic                valid_r;
  logic [ADC_BITS-1:0] code_r, code_nxt, diff;
  logic [NUM_W-1:0]    num_r, num_nxt;
  tac_flags_t          flags_r, flags_nxt;

  // raise code zero, classify zero resistance, form the divider numerator
  always_comb begin
    flags_nxt.raised = (in_adc_code == '0);
    code_nxt         = flags_nxt.raised ? ADC_BITS'(1) : in_adc_code;
    flags_nxt.zero_r = (code_nxt == FS) || (series_ohms == '0);
    diff             = FS - code_nxt;
    num_nxt          = NUM_W'(series_ohms) * NUM_W'(diff);
  end

  assign in_ready = !valid_r || q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r  <= code_nxt;
      num_r   <= num_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign q_valid = valid_r;
  assign q_code  = code_r;
  assign q_num   = num_r;
  assign q_flags = flags_r;

  `TAC_ASSERT_IMP(a_raised_code, valid_r && flags_r.raised, code_r == ADC_BITS'(1), "raised code not one")

endmodule

/* hdl/tac_queue.sv */
`include "assert_macros.svh"

module tac_queue #(
  parameter int W     = 8,
  parameter int DEPTH = tac_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push_do, pop_do;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push_do    = push_valid && push_ready;
  assign pop_do     = pop && pop_valid;
  assign pop_data   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_do) begin
        wr_r <= wr_r + PTR_W'(1);
      end
      if (pop_do) begin
        rd_r <= rd_r + PTR_W'(1);
      end
      if (push_do && !pop_do) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop_do && !push_do) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_do) begin
      mem[wr_r] <= push_data;
    end
  end

  `TAC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count above depth")
  `TAC_ASSERT_NEXT(a_cnt_inc, push_do && !pop_do, cnt_r == $past(cnt_r) + CNT_W'(1), "queue count lost a push")

endmodule

/* hdl/tac_log2.sv */
module tac_log2 #(
  parameter int XW = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [XW-1:0]              x,
  output logic [$clog2(XW)+31:0]     lg
);
  localparam int E_W = $clog2(XW);
  localparam int NR  = 32;

  logic [E_W-1:0]   e_nxt;
  logic [XW+30:0]   wide;
  logic [31:0]      m_r [NR+1];
  logic [31:0]      f_r [NR+1];
  logic [E_W-1:0]   e_r [NR+1];

  // top set bit, then normalize to Q1.31
  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) begin
        e_nxt = E_W'(i);
      end
    end
    wide = {x, 31'b0} >> e_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= wide[31:0];
      f_r[0] <= '0;
      e_r[0] <= e_nxt;
    end
  end

  // one fraction bit per squaring stage
  for (genvar g = 0; g < NR; g++) begin : g_round
    logic [63:0] prod;
    logic [32:0] mm;
    assign prod = m_r[g] * m_r[g];
    assign mm   = prod[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[g+1] <= mm[32] ? mm[32:1] : mm[31:0];
        f_r[g+1] <= {f_r[g][30:0], mm[32]};
        e_r[g+1] <= e_r[g];
      end
    end
  end

  assign lg = {e_r[NR], f_r[NR]};

endmodule

/* hdl/tac_mul.sv */
module tac_mul #(
  parameter int AW = 40,
  parameter int BW = 40
) (
  input  logic               clk,
  input  logic               en,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-33:0]  p
);
  localparam int AH = AW - 32;
  localparam int BH = BW - 32;
  localparam int SW = AW + BW - 32;

  logic [63:0]       ll_r;
  logic [BW-1:0]     lh_r;
  logic [AW-1:0]     hl_r;
  logic [AH+BH-1:0]  hh_r;
  logic [SW-1:0]     p_r, sum;

  // floor(a*b / 2^32) from four registered partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[31:0] * b[31:0];
      lh_r <= a[31:0] * b[BW-1:32];
      hl_r <= a[AW-1:32] * b[31:0];
      hh_r <= a[AW-1:32] * b[BW-1:32];
    end
  end

  assign sum = {hh_r, 32'b0} + SW'(lh_r) + SW'(hl_r) + SW'(ll_r[63:32]);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum;
    end
  end

  assign p = p_r;

endmodule

/* hdl/tac_back.sv */
`include "assert_macros.svh"

module tac_back #(
  parameter int ADC_BITS       = tac_pkg::ADC_BITS_DEF,
  parameter int COEF_FRAC_BITS = tac_pkg::COEF_FRAC_DEF,
  parameter int TEMP_FRAC_BITS = tac_pkg::TEMP_FRAC_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [tac_pkg::COEF_W-1:0]            coef_a,
  input  logic [tac_pkg::COEF_W-1:0]            coef_b,
  input  logic [tac_pkg::COEF_W-1:0]            coef_c,
  input  logic                                  q_valid,
  output logic                                  q_pop,
  input  logic [ADC_BITS-1:0]                   q_code,
  input  logic [tac_pkg::SERIES_W+ADC_BITS-1:0] q_num,
  input  tac_pkg::tac_flags_t                   q_flags,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [tac_pkg::TEMP_W-1:0]            out_temp,
  output tac_pkg::tac_flags_t                   out_flags
);
  import tac_pkg::*;

  localparam int NUM_W = SERIES_W + ADC_BITS;
  localparam int EN_W  = $clog2(NUM_W);
  localparam int EC_W  = $clog2(ADC_BITS);
  localparam int LN_W  = EN_W + 32;
  localparam int U_W   = LN_W;
  localparam int SQ_W  = 2 * U_W - 32;
  localparam int CU_W  = SQ_W + U_W - 32;
  localparam int TB_W  = COEF_W + U_W - 32;
  localparam int TC_W  = COEF_W + CU_W - 32;
  localparam int T_W   = TC_W + 1;
  localparam int XS_W  = T_W + 2;
  localparam int X_W   = T_W + 1;
  localparam int K     = COEF_FRAC_BITS + TEMP_FRAC_BITS + 1;
  localparam int NSTEP = K + 1;
  localparam int Q_W   = (NSTEP < SAT_BIT) ? NSTEP : SAT_BIT;
  localparam int DW    = Q_W + 2;
  localparam int LAT   = K + 43;
  localparam int OFF   = ((27315 << TEMP_FRAC_BITS) + 50) / 100;
  localparam int ZT    = (OFF > 131072) ? OUT_MIN : -OFF;

  localparam logic signed [DW-1:0] OFF_S = DW'(OFF);
  localparam logic signed [DW-1:0] MAX_S = DW'(OUT_MAX);
  localparam logic signed [DW-1:0] MIN_S = DW'(OUT_MIN);

  logic                en;
  logic                vld_r [LAT];
  tac_flags_t          flg_r [LAT];
  logic [LN_W-1:0]     ln_n, ln_c_ext, d_r, d_nxt;
  logic [EC_W+31:0]    ln_c;
  logic                neg_nxt;
  logic                neg_r [8];
  logic [LN_W+23:0]    ulong;
  logic [U_W-1:0]      u_r, u_d1_r, u_d2_r;
  logic [SQ_W-1:0]     sq;
  logic [CU_W-1:0]     cube;
  logic [TB_W-1:0]     tb;
  logic [TB_W-1:0]     tb_r [4];
  logic [TC_W-1:0]     tc;
  logic [T_W-1:0]      tsum;
  logic [XS_W-1:0]     xs;
  logic                xpos;
  logic [X_W-1:0]      dr_r [NSTEP+1];
  logic [X_W-1:0]      dx_r [NSTEP+1];
  logic [Q_W-1:0]      dq_r [NSTEP+1];
  logic                ds_r [NSTEP+1];
  logic [Q_W:0]        ksum;
  logic signed [DW-1:0] diff;
  logic [TEMP_W-1:0]   temp_nxt;
  logic                out_valid_r;
  logic [TEMP_W-1:0]   out_temp_r;
  tac_flags_t          out_flags_r;

  // the whole back pipeline advances whenever the output register can load
  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= q_valid;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flg_r[0] <= q_flags;
      for (int i = 1; i < LAT; i++) begin
        flg_r[i] <= flg_r[i-1];
      end
    end
  end

  tac_log2 #(.XW(NUM_W)) u_log_num (
    .clk (clk),
    .en  (en),
    .x   (q_num),
    .lg  (ln_n)
  );

  tac_log2 #(.XW(ADC_BITS)) u_log_code (
    .clk (clk),
    .en  (en),
    .x   (q_code),
    .lg  (ln_c)
  );

  // log difference as sign and magnitude
  always_comb begin
    ln_c_ext = LN_W'(ln_c);
    neg_nxt  = ln_n < ln_c_ext;
    d_nxt    = neg_nxt ? (ln_c_ext - ln_n) : (ln_n - ln_c_ext);
  end

  assign ulong = (LN_W+24)'(d_r) * (LN_W+24)'(LN2_Q24);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r      <= d_nxt;
      neg_r[0] <= neg_nxt;
      for (int i = 1; i < 8; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
      u_r    <= ulong[LN_W+23:24];
      u_d1_r <= u_r;
      u_d2_r <= u_d1_r;
      tb_r[0] <= tb;
      for (int i = 1; i < 4; i++) begin
        tb_r[i] <= tb_r[i-1];
      end
    end
  end

  tac_mul #(.AW(U_W), .BW(U_W)) u_mul_sq (
    .clk (clk), .en (en), .a (u_r), .b (u_r), .p (sq)
  );

  tac_mul #(.AW(COEF_W), .BW(U_W)) u_mul_tb (
    .clk (clk), .en (en), .a (coef_b), .b (u_r), .p (tb)
  );

  tac_mul #(.AW(SQ_W), .BW(U_W)) u_mul_cube (
    .clk (clk), .en (en), .a (sq), .b (u_d2_r), .p (cube)
  );

  tac_mul #(.AW(COEF_W), .BW(CU_W)) u_mul_tc (
    .clk (clk), .en (en), .a (coef_c), .b (cube), .p (tc)
  );

  // 1/T sum; a nonpositive sum enters the divider as zero and saturates high
  always_comb begin
    tsum = T_W'(tb_r[3]) + T_W'(tc);
    xs   = neg_r[7] ? (XS_W'(coef_a) - XS_W'(tsum)) : (XS_W'(coef_a) + XS_W'(tsum));
    xpos = !xs[XS_W-1] && (xs != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr_r[0] <= '0;
      dx_r[0] <= xpos ? xs[X_W-1:0] : '0;
      dq_r[0] <= '0;
      ds_r[0] <= 1'b0;
    end
  end

  // restoring divider for 2^K / x, one quotient bit per stage
  for (genvar s = 0; s < NSTEP; s++) begin : g_div
    localparam int I = K - s;
    logic [X_W:0] rsh, rdif;
    logic         ge;
    assign rsh  = {dr_r[s], (s == 0) ? 1'b1 : 1'b0};
    assign rdif = rsh - {1'b0, dx_r[s]};
    assign ge   = (rsh >= {1'b0, dx_r[s]});
    always_ff @(posedge clk) begin
      if (en) begin
        dr_r[s+1] <= ge ? rdif[X_W-1:0] : rsh[X_W-1:0];
        dx_r[s+1] <= dx_r[s];
      end
    end
    if (I >= SAT_BIT) begin : g_sat
      always_ff @(posedge clk) begin
        if (en) begin
          dq_r[s+1] <= dq_r[s];
          ds_r[s+1] <= ds_r[s] || ge;
        end
      end
    end else begin : g_q
      always_ff @(posedge clk) begin
        if (en) begin
          dq_r[s+1] <= {dq_r[s][Q_W-2:0], ge};
          ds_r[s+1] <= ds_r[s];
        end
      end
    end
  end

  // round to kelvin, subtract the offset, saturate
  always_comb begin
    ksum = (Q_W+1)'(dq_r[NSTEP]) + (Q_W+1)'(1);
    diff = $signed({2'b00, ksum[Q_W:1]}) - OFF_S;
    if (flg_r[LAT-1].zero_r) begin
      temp_nxt = TEMP_W'(ZT);
    end else if (ds_r[NSTEP] || (diff > MAX_S)) begin
      temp_nxt = TEMP_W'(OUT_MAX);
    end else if (diff < MIN_S) begin
      temp_nxt = TEMP_W'(OUT_MIN);
    end else begin
      temp_nxt = diff[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp_r  <= temp_nxt;
      out_flags_r <= flg_r[LAT-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_temp  = out_temp_r;
  assign out_flags = out_flags_r;

  `TAC_ASSERT_IMP(a_zero_temp, out_valid_r && out_flags_r.zero_r, out_temp_r == TEMP_W'(ZT), "zero resistance result not clamped")

endmodule

/* hdl/thermistor_adc_to_celsius.sv */
// Thermistor ADC code to temperature, Steinhart-Hart linearization.
//
// Input channel (in_valid/in_ready/in_adc_code): one request per ADC code.
// Result channel (out_valid/out_ready/out_*): one result per request, in order:
// temperature in signed 1/2^TEMP_FRAC_BITS degC steps, plus two flags: a code
// of zero was raised to one, and a full-scale code (or a zero series resistor)
// gave zero resistance, with the output clamped to absolute zero.
// Configuration: write cfg_wdata into register cfg_index while cfg_we is high;
// coef_a/b/c are unsigned Q0.48 terms, series_ohms the divider resistor.
// Write them only while no request is in flight.
//
// Throughput: one code per cycle while the receiver does not stall. Results
// pass from acceptance to out_valid through the 32-stage log2 squaring chain
// and the restoring divider that yields one quotient bit per stage.
// Reset (synchronous, rst_n low) empties the pipeline and reloads the
// coefficient defaults; no clearing pass follows. When the receiver stalls,
// the result register holds, the back pipeline freezes, and the front keeps
// taking requests until its own register and the four-entry queue are full.
module thermistor_adc_to_celsius #(
  parameter int ADC_BITS       = tac_pkg::ADC_BITS_DEF,
  parameter int COEF_FRAC_BITS = tac_pkg::COEF_FRAC_DEF,
  parameter int TEMP_FRAC_BITS = tac_pkg::TEMP_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ADC_BITS-1:0]                  in_adc_code,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tac_pkg::TEMP_W-1:0]    out_temp_celsius,
  output logic                                 out_code_raised,
  output logic                                 out_zero_resistance,
  input  logic                                 cfg_we,
  input  logic [tac_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tac_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import tac_pkg::*;

  localparam int NUM_W = SERIES_W + ADC_BITS;
  localparam int QW    = $bits(tac_flags_t) + ADC_BITS + NUM_W;

  logic [COEF_W-1:0]   coef_a_r, coef_b_r, coef_c_r;
  logic [SERIES_W-1:0] series_r;

  logic                f_valid, f_ready;
  logic [ADC_BITS-1:0] f_code, b_code;
  logic [NUM_W-1:0]    f_num, b_num;
  tac_flags_t          f_flags, b_flags, o_flags;
  logic [QW-1:0]       b_data;
  logic                b_valid, b_pop;
  logic [TEMP_W-1:0]   o_temp;

  // Configuration registers: writes to them are taken at once, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= COEF_A_RST;
      coef_b_r <= COEF_B_RST;
      coef_c_r <= COEF_C_RST;
      series_r <= SERIES_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEF_A: coef_a_r <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_B: coef_b_r <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_C: coef_c_r <= cfg_wdata[COEF_W-1:0];
        CFG_SERIES: series_r <= cfg_wdata[SERIES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept the code, raise zero, flag zero resistance, form R numerator.
  tac_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_adc_code (in_adc_code),
    .series_ohms (series_r),
    .q_valid     (f_valid),
    .q_ready     (f_ready),
    .q_code      (f_code),
    .q_num       (f_num),
    .q_flags     (f_flags)
  );

  // Short queue decouples the front from a stalled back pipeline.
  tac_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_flags, f_code, f_num}),
    .pop_valid  (b_valid),
    .pop        (b_pop),
    .pop_data   (b_data)
  );

  assign {b_flags, b_code, b_num} = b_data;

  // Back: logs, polynomial, reciprocal, offset and saturation.
  tac_back #(
    .ADC_BITS       (ADC_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef_a    (coef_a_r),
    .coef_b    (coef_b_r),
    .coef_c    (coef_c_r),
    .q_valid   (b_valid),
    .q_pop     (b_pop),
    .q_code    (b_code),
    .q_num     (b_num),
    .q_flags   (b_flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_temp  (o_temp),
    .out_flags (o_flags)
  );

  assign out_temp_celsius    = o_temp;
  assign out_code_raised     = o_flags.raised;
  assign out_zero_resistance = o_flags.zero_r;

endmodule
